// ----- hdl/assert_macros.svh -----
// Assertion macros used by dvq_ctrl, the sequencer of the visit queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DVQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dvq_pkg.sv -----
// Package of the deduplicating visit queue: contact and result types, codes.
// Used by dvq_ram, dvq_ctrl and dedup_visit_queue; depends on nothing.
`default_nettype none

package dvq_pkg;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // Address sits in the lowest bits so the packed form matches tdata.
  typedef struct packed {
    logic [15:0] port;
    logic [63:0] id;
    logic [31:0] address;
  } contact_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  entry_count;
    logic        pending;
    contact_t    contact;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/dvq_ram.sv -----
// Contact memory of the visit queue: one write and one registered read per cycle.
// Depends on dvq_pkg for the contact type.
`default_nettype none

module dvq_ram
  import dvq_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire contact_t      wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output contact_t           rd_data
);

  contact_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dvq_ctrl.sv -----
// Sequencer of the visit queue: duplicate scan, append and take over the contact memory.
// Depends on dvq_pkg and assert_macros.svh; drives one dvq_ram.
`default_nettype none

`include "assert_macros.svh"

module dvq_ctrl
  import dvq_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_command,
  input  wire contact_t      in_contact,
  output logic               res_valid,
  input  wire logic          res_ready,
  output result_t            res,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output contact_t           wr_data,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire contact_t      rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_TAKE, S_HOLD} state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic            hit_r, hit_nxt;
  contact_t        req_r, req_nxt;
  status_t         stat_r, stat_nxt;
  contact_t        out_r, out_nxt;

  // Takes always check the lowest unchecked entry, so the checked entries form
  // a prefix of the table and head_r marks its end.
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    head_nxt    = head_r;
    scan_nxt    = scan_r;
    cmp_vld_nxt = cmp_vld_r;
    hit_nxt     = hit_r;
    req_nxt     = req_r;
    stat_nxt    = stat_r;
    out_nxt     = out_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = fill_r[AW-1:0];
    wr_data     = req_r;
    in_ready    = (state_r == S_IDLE);
    res_valid   = (state_r == S_HOLD);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == CMD_ADD) begin
            req_nxt     = in_contact;
            scan_nxt    = '0;
            hit_nxt     = 1'b0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end else if (head_r == fill_r) begin
            stat_nxt  = STAT_EMPTY;
            out_nxt   = '0;
            state_nxt = S_HOLD;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r[AW-1:0];
            state_nxt = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        out_nxt   = rd_data;
        stat_nxt  = STAT_OK;
        head_nxt  = head_r + 1'b1;
        state_nxt = S_HOLD;
      end
      S_SCAN: begin
        cmp_vld_nxt = 1'b0;
        if (cmp_vld_r && (rd_data == req_r)) begin
          hit_nxt = 1'b1;
        end
        if (scan_r != fill_r) begin
          rd_en       = 1'b1;
          rd_addr     = scan_r[AW-1:0];
          scan_nxt    = scan_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end else if (!cmp_vld_r) begin
          out_nxt   = '0;
          state_nxt = S_HOLD;
          if (hit_r) begin
            stat_nxt = STAT_DUP;
          end else if (fill_r == CW'(DEPTH)) begin
            stat_nxt = STAT_FULL;
          end else begin
            stat_nxt = STAT_OK;
            wr_en    = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      S_HOLD: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      head_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      head_r    <= head_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
    scan_r <= scan_nxt;
    hit_r  <= hit_nxt;
    req_r  <= req_nxt;
    stat_r <= stat_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    res.status      = stat_r;
    res.entry_count = 7'(fill_r);
    res.pending     = (head_r != fill_r);
    res.contact     = out_r;
  end

  `DVQ_ASSERT_SAME(a_head_within_fill, 1'b1, head_r <= fill_r, "take pointer passed fill count")
  `DVQ_ASSERT_SAME(a_fill_within_depth, 1'b1, fill_r <= CW'(DEPTH), "fill count above depth")
  `DVQ_ASSERT_SAME(a_write_not_full, wr_en, fill_r < CW'(DEPTH) && !hit_r, "append to full table")
  `DVQ_ASSERT_NEXT(a_append_grows, wr_en, fill_r == $past(fill_r) + 1'b1, "append lost")

endmodule

`default_nettype wire

// ----- hdl/dedup_visit_queue.sv -----
// Top level of the deduplicating visit queue: stream ports and result register.
// Depends on dvq_pkg, dvq_ram and dvq_ctrl.
//
// Usage: each request on the in_ stream is either an add of a contact
// (in_tuser = 0) or a take of the oldest unchecked contact (in_tuser = 1).
// Every request yields exactly one result on the out_ stream, in order.
// An add reads every stored entry once through the single read port of the
// contact memory to look for a duplicate, then appends unless it found one or
// the table is full. A take reads one entry; a take on a table with nothing
// unchecked reads none and returns an empty status.
// The result is held by the sequencer, then moved into the output register that drives out_tvalid.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits for out_tready; a stalled receiver
// holds the sequencer only once a second result is ready.
// Reset empties the table at once: the fill count and take pointer clear,
// and the contact memory itself needs no clearing pass.
`default_nettype none

module dedup_visit_queue
  import dvq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,   // peer_address, peer_id, peer_port
  input  wire logic         in_tuser,   // command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [119:0]      out_tdata,  // out_address, out_id, out_port, pending, entry_count
  output logic [1:0]        out_tuser   // status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  contact_t      wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  contact_t      rd_data;
  logic          res_valid;
  logic          slot_free;
  result_t       res;
  logic          out_tvalid_r;
  result_t       out_r;

  assign slot_free = !out_tvalid_r || out_tready;

  dvq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_command (in_tuser),
    .in_contact (contact_t'(in_tdata)),
    .res_valid  (res_valid),
    .res_ready  (slot_free),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  dvq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (slot_free) begin
      out_tvalid_r <= res_valid;
    end
    if (slot_free && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_r.entry_count, out_r.pending, out_r.contact};
  assign out_tuser  = out_r.status;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for dedup_visit_queue: directed rows, then random add and take requests.
// Expected results come from a scoreboard model of the contact table kept in this file,
// or from the fixed results of directed rows. Depends on dvq_pkg and the dedup_visit_queue RTL.
`default_nettype none

module tb;
  import dvq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int RANDOM_REQS = 1730;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 100;

  typedef struct {
    logic     cmd;
    contact_t peer;
    bit       has_fixed;
    result_t  fixed;
  } req_row_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata   = '0;
  logic         in_tuser   = CMD_ADD;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [1:0]   out_tuser;

  contact_t seen_contact [DEPTH];
  bit       visited      [DEPTH];
  int       n_seen;

  result_t  awaited_results [$];
  req_row_t script          [$];

  int send_gap_pct = 36;
  int recv_gap_pct = 70;
  int mismatches   = 0;
  int checked      = 0;
  int status_seen  [4];
  int peak_fill    = 0;

  dedup_visit_queue #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic contact_t peer(logic [31:0] a, logic [63:0] i, logic [15:0] p);
    contact_t c;
    c.address = a;
    c.id      = i;
    c.port    = p;
    return c;
  endfunction

  function automatic result_t mk(status_t s, int cnt, logic pend, contact_t c);
    result_t r;
    r.status      = s;
    r.entry_count = cnt[6:0];
    r.pending     = pend;
    r.contact     = c;
    return r;
  endfunction

  function automatic req_row_t row(logic cmd, contact_t c, bit has_fixed, result_t fixed);
    req_row_t r;
    r.cmd       = cmd;
    r.peer      = c;
    r.has_fixed = has_fixed;
    r.fixed     = fixed;
    return r;
  endfunction

  function automatic void queue_row(req_row_t r);
    script = {script, r};
  endfunction

  function automatic contact_t rand_contact();
    return peer($urandom, {$urandom, $urandom}, 16'($urandom_range(65535)));
  endfunction

  function automatic result_t predict_visit(logic cmd, contact_t c);
    result_t r;
    bit      dup;
    r = mk(STAT_OK, 0, 1'b0, '0);
    if (cmd == CMD_ADD) begin
      dup = 1'b0;
      for (int k = 0; k < n_seen; k++)
        if (seen_contact[k] == c) dup = 1'b1;
      if (dup) begin
        r.status = STAT_DUP;
      end else if (n_seen >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        seen_contact[n_seen] = c;
        visited[n_seen]      = 1'b0;
        n_seen++;
      end
    end else begin
      r.status = STAT_EMPTY;
      for (int k = 0; k < n_seen; k++) begin
        if (!visited[k] && r.status == STAT_EMPTY) begin
          visited[k] = 1'b1;
          r.contact  = seen_contact[k];
          r.status   = STAT_OK;
        end
      end
    end
    for (int k = 0; k < n_seen; k++)
      if (!visited[k]) r.pending = 1'b1;
    r.entry_count = n_seen[6:0];
    return r;
  endfunction

  task automatic send_request(logic cmd, contact_t c, bit has_fixed, result_t fixed);
    result_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_visit(cmd, c);
    if (n_seen > peak_fill) peak_fill = n_seen;
    awaited_results = {awaited_results, (has_fixed ? fixed : want)};
  endtask

  task automatic pick_request(output logic cmd, output contact_t c);
    int r;
    r = $urandom_range(99);
    c = rand_contact();
    if (r < 50) begin
      cmd = CMD_TAKE;
    end else begin
      cmd = CMD_ADD;
      r = $urandom_range(99);
      if (n_seen != 0 && r < 84)
        c = seen_contact[$urandom_range(n_seen - 1)];
      else if (n_seen != 0 && r < 92)
        c = seen_contact[$urandom_range(n_seen - 1)] ^ (112'b1 << $urandom_range(111));
    end
  endtask

  task automatic note_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d, %s: expected %0h, got %0h", checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    out_tready <= ($urandom_range(99) >= recv_gap_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'({out_tuser, out_tdata});
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result with status %0d and count %0d", got.status,
                   got.entry_count);
      end else begin
        want = awaited_results.pop_front();
        note_field("status", 64'(want.status), 64'(got.status));
        note_field("address", 64'(want.contact.address), 64'(got.contact.address));
        note_field("id", want.contact.id, got.contact.id);
        note_field("port", 64'(want.contact.port), 64'(got.contact.port));
        note_field("pending", 64'(want.pending), 64'(got.pending));
        note_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
        status_seen[got.status]++;
        checked++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run exceeded %0d cycles with %0d results outstanding", CYCLE_LIMIT,
             awaited_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    contact_t zero;
    contact_t ones;
    result_t  dummy;
    logic     cmd;
    contact_t c;
    int       directed;

    zero  = '0;
    ones  = '1;
    dummy = mk(STAT_OK, 0, 1'b0, zero);
    n_seen = 0;
    for (int k = 0; k < DEPTH; k++) visited[k] = 1'b0;
    for (int k = 0; k < 4; k++) status_seen[k] = 0;

    queue_row(row(CMD_TAKE, zero, 1, mk(STAT_EMPTY, 0, 1'b0, zero)));
    queue_row(row(CMD_ADD, zero, 1, mk(STAT_OK, 1, 1'b1, zero)));
    queue_row(row(CMD_ADD, zero, 1, mk(STAT_DUP, 1, 1'b1, zero)));
    queue_row(row(CMD_ADD, ones, 1, mk(STAT_OK, 2, 1'b1, zero)));
    queue_row(row(CMD_ADD, peer('1, '1, '0), 0, dummy));
    queue_row(row(CMD_ADD, peer('1, '0, '0), 0, dummy));
    queue_row(row(CMD_ADD, peer('0, '1, '0), 0, dummy));
    queue_row(row(CMD_ADD, peer('0, '0, '1), 0, dummy));
    queue_row(row(CMD_TAKE, ones, 1, mk(STAT_OK, 6, 1'b1, zero)));
    queue_row(row(CMD_TAKE, zero, 1, mk(STAT_OK, 6, 1'b1, ones)));
    queue_row(row(CMD_ADD, ones, 1, mk(STAT_DUP, 6, 1'b1, zero)));
    repeat (4) queue_row(row(CMD_TAKE, zero, 0, dummy));
    queue_row(row(CMD_TAKE, zero, 1, mk(STAT_EMPTY, 6, 1'b0, zero)));
    queue_row(row(CMD_TAKE, peer(32'h8000_0001, 64'hdead_beef_0123_4567, 16'h5a5a), 1,
                  mk(STAT_EMPTY, 6, 1'b0, zero)));
    queue_row(row(CMD_ADD, peer(32'h8000_0000, 64'h8000_0000_0000_0000, 16'h8000), 0,
                  dummy));
    queue_row(row(CMD_ADD, peer(32'h7fff_ffff, 64'h7fff_ffff_ffff_ffff, 16'h7fff), 0,
                  dummy));
    queue_row(row(CMD_ADD, peer(32'h8000_0000, 64'h8000_0000_0000_0000, 16'h8000), 1,
                  mk(STAT_DUP, 8, 1'b1, zero)));
    queue_row(row(CMD_TAKE, zero, 0, dummy));
    directed = script.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k])
      send_request(script[k].cmd, script[k].peer, script[k].has_fixed, script[k].fixed);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        send_gap_pct = 70;
        recv_gap_pct = 36;
      end else if (n == 2 * RANDOM_REQS / 3) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      pick_request(cmd, c);
      send_request(cmd, c, 0, dummy);
    end
    in_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests (%0d directed), checked %0d results; table peaked at %0d of %0d.",
             directed + RANDOM_REQS, directed, checked, peak_fill, DEPTH);
    $display("Status counts: ok %0d, duplicate %0d, full %0d, empty %0d; mismatches %0d.",
             status_seen[STAT_OK], status_seen[STAT_DUP], status_seen[STAT_FULL],
             status_seen[STAT_EMPTY], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/dvq_pkg.sv
hdl/dvq_ram.sv
hdl/dvq_ctrl.sv
hdl/dedup_visit_queue.sv
tb/sv/tb.sv
